// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// No dependencies; take it in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising edge of clk, off while rst_n is low.
`define ABP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: property violated");

// Assert that a condition never holds on a rising edge of clk.
`define ABP_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("%m: forbidden condition seen");

`endif

// ===== rtl/core/abp_pkg.sv =====
// Constants and helpers for the alpha blend pixel pipeline.
// No dependencies; used by the top level and its checker.
package abp_pkg;

	localparam int unsigned CHAN_W  = 8;
	localparam int unsigned COORD_W = 13;
	localparam int unsigned DIM_W   = 13;
	localparam int unsigned PROD_W  = 2 * CHAN_W;
	localparam int unsigned CFG_IDX_W = 2;

	// Largest surface size used for clipping.
	localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(4096);

	localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_ALPHA   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_HEIGHT = 2'd2;

	localparam logic [CHAN_W-1:0] RST_GLOBAL_ALPHA   = 8'd255;
	localparam logic [DIM_W-1:0]  RST_SURFACE_WIDTH  = 13'd640;
	localparam logic [DIM_W-1:0]  RST_SURFACE_HEIGHT = 13'd480;

	// Truncating divide by 255, exact for x up to 255 * 255.
	function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
		logic [PROD_W:0] sum;
		sum = {1'b0, x} + (PROD_W+1)'(1) + (PROD_W+1)'(x >> CHAN_W);
		return sum[PROD_W-1:CHAN_W];
	endfunction

	// Clamp a surface size to the supported maximum.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
		return (d > MAX_DIM) ? MAX_DIM : d;
	endfunction

endpackage

// ===== rtl/core/alpha_blend_pixel_top.sv =====
// Source-over ARGB8888 pixel blender, four-stage pipeline.
// Depends on abp_pkg (constants, divide-by-255 helper).
//
// Usage:
//   Input channel: raise start with one source pixel, the destination pixel
//   under it and its signed coordinates. busy stays low, so a word is taken
//   at every rising edge with start high: one pixel per clock.
//   Result channel: done marks one result word for exactly one cycle. The
//   word is registered in each of the pipeline stages and comes out in input
//   order. The receiver cannot hold results off, so the pipeline never stalls.
//   Configuration: cfg_we with cfg_index / cfg_data writes global alpha,
//   surface width or surface height; index 3 is dropped. Write only while
//   no pixel is in flight.
//   Reset: arst_n low clears all stage valid bits and loads global alpha
//   255 and a 640 x 480 surface. Pixels in flight are dropped.
//   Clipped pixels and pixels whose scaled alpha is zero come out with
//   write_enable low and all channels zero.
module alpha_blend_pixel_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// command channel
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [abp_pkg::COORD_W-1:0]     dest_x,
	input  logic signed [abp_pkg::COORD_W-1:0]     dest_y,
	input  logic        [abp_pkg::CHAN_W-1:0]      src_alpha,
	input  logic        [abp_pkg::CHAN_W-1:0]      src_red,
	input  logic        [abp_pkg::CHAN_W-1:0]      src_green,
	input  logic        [abp_pkg::CHAN_W-1:0]      src_blue,
	input  logic        [abp_pkg::CHAN_W-1:0]      dst_alpha,
	input  logic        [abp_pkg::CHAN_W-1:0]      dst_red,
	input  logic        [abp_pkg::CHAN_W-1:0]      dst_green,
	input  logic        [abp_pkg::CHAN_W-1:0]      dst_blue,
	// result channel
	output logic                                   done,
	output logic                                   write_enable,
	output logic        [abp_pkg::CHAN_W-1:0]      out_alpha,
	output logic        [abp_pkg::CHAN_W-1:0]      out_red,
	output logic        [abp_pkg::CHAN_W-1:0]      out_green,
	output logic        [abp_pkg::CHAN_W-1:0]      out_blue,
	// configuration write port
	input  logic                                   cfg_we,
	input  logic        [abp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic        [abp_pkg::DIM_W-1:0]       cfg_data
);

	localparam int unsigned CW = abp_pkg::CHAN_W;
	localparam int unsigned PW = abp_pkg::PROD_W;
	localparam int unsigned DW = abp_pkg::DIM_W;

	// Configuration registers.
	logic [CW-1:0] global_alpha_q;
	logic [DW-1:0] surface_width_q;
	logic [DW-1:0] surface_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			global_alpha_q   <= abp_pkg::RST_GLOBAL_ALPHA;
			surface_width_q  <= abp_pkg::RST_SURFACE_WIDTH;
			surface_height_q <= abp_pkg::RST_SURFACE_HEIGHT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				abp_pkg::CFG_GLOBAL_ALPHA:   global_alpha_q   <= cfg_data[CW-1:0];
				abp_pkg::CFG_SURFACE_WIDTH:  surface_width_q  <= cfg_data;
				abp_pkg::CFG_SURFACE_HEIGHT: surface_height_q <= cfg_data;
				default: ; // drop writes to unused indexes
			endcase
		end
	end

	// The pipeline takes a word every cycle.
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// ---------------------------------------------------------------
	// Stage 1: clip test and source alpha times global alpha.
	// ---------------------------------------------------------------
	logic [DW-1:0] width_lim;
	logic [DW-1:0] height_lim;
	logic          in_bounds;

	assign width_lim  = abp_pkg::clamp_dim(surface_width_q);
	assign height_lim = abp_pkg::clamp_dim(surface_height_q);
	// A negative coordinate is always outside; otherwise compare unsigned.
	assign in_bounds = !dest_x[abp_pkg::COORD_W-1] && !dest_y[abp_pkg::COORD_W-1]
		&& (DW'(unsigned'(dest_x)) < width_lim)
		&& (DW'(unsigned'(dest_y)) < height_lim);

	logic          vld_s1;
	logic          in_bounds_s1;
	logic [PW-1:0] aprod_s1;
	logic [CW-1:0] sr_s1, sg_s1, sb_s1;
	logic [CW-1:0] da_s1, dr_s1, dg_s1, db_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		in_bounds_s1 <= in_bounds;
		aprod_s1     <= PW'(src_alpha) * PW'(global_alpha_q);
		sr_s1        <= src_red;
		sg_s1        <= src_green;
		sb_s1        <= src_blue;
		da_s1        <= dst_alpha;
		dr_s1        <= dst_red;
		dg_s1        <= dst_green;
		db_s1        <= dst_blue;
	end

	// ---------------------------------------------------------------
	// Stage 2: scaled alpha = product / 255.
	// ---------------------------------------------------------------
	logic          vld_s2;
	logic          in_bounds_s2;
	logic [CW-1:0] alpha_s2;
	logic [CW-1:0] sr_s2, sg_s2, sb_s2;
	logic [CW-1:0] da_s2, dr_s2, dg_s2, db_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		in_bounds_s2 <= in_bounds_s1;
		alpha_s2     <= abp_pkg::div255(aprod_s1);
		sr_s2        <= sr_s1;
		sg_s2        <= sg_s1;
		sb_s2        <= sb_s1;
		da_s2        <= da_s1;
		dr_s2        <= dr_s1;
		dg_s2        <= dg_s1;
		db_s2        <= db_s1;
	end

	// ---------------------------------------------------------------
	// Stage 3: per-channel weighted sums s*a + d*(255-a); one lane each.
	// ---------------------------------------------------------------
	logic [CW-1:0] inv_alpha;
	assign inv_alpha = abp_pkg::CHAN_MAX - alpha_s2;

	logic          vld_s3;
	logic          write_s3;
	logic          opaque_s3;
	logic [CW-1:0] alpha_s3;
	logic [CW-1:0] sr_s3, sg_s3, sb_s3;
	logic [PW-1:0] mix_r_s3, mix_g_s3, mix_b_s3;
	logic [PW-1:0] dst_a_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		write_s3  <= in_bounds_s2 && (alpha_s2 != '0);
		opaque_s3 <= (alpha_s2 == abp_pkg::CHAN_MAX);
		alpha_s3  <= alpha_s2;
		sr_s3     <= sr_s2;
		sg_s3     <= sg_s2;
		sb_s3     <= sb_s2;
		// Sums never exceed 255 * 255, so 16 bits hold them.
		mix_r_s3  <= PW'(PW'(sr_s2) * PW'(alpha_s2) + PW'(dr_s2) * PW'(inv_alpha));
		mix_g_s3  <= PW'(PW'(sg_s2) * PW'(alpha_s2) + PW'(dg_s2) * PW'(inv_alpha));
		mix_b_s3  <= PW'(PW'(sb_s2) * PW'(alpha_s2) + PW'(db_s2) * PW'(inv_alpha));
		dst_a_s3  <= PW'(da_s2) * PW'(inv_alpha);
	end

	// ---------------------------------------------------------------
	// Stage 4: divide by 255, pick opaque / blended / skipped result.
	// ---------------------------------------------------------------
	logic          vld_s4;
	logic          we_s4;
	logic [CW-1:0] alpha_s4, red_s4, green_s4, blue_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		we_s4 <= write_s3;
		priority if (!write_s3) begin
			// clipped or fully transparent: report zeros
			alpha_s4 <= '0;
			red_s4   <= '0;
			green_s4 <= '0;
			blue_s4  <= '0;
		end else if (opaque_s3) begin
			// opaque source replaces the destination
			alpha_s4 <= abp_pkg::CHAN_MAX;
			red_s4   <= sr_s3;
			green_s4 <= sg_s3;
			blue_s4  <= sb_s3;
		end else begin
			// alpha accumulates; sum never exceeds 255
			alpha_s4 <= alpha_s3 + abp_pkg::div255(dst_a_s3);
			red_s4   <= abp_pkg::div255(mix_r_s3);
			green_s4 <= abp_pkg::div255(mix_g_s3);
			blue_s4  <= abp_pkg::div255(mix_b_s3);
		end
	end

	assign done         = vld_s4;
	assign write_enable = we_s4;
	assign out_alpha    = alpha_s4;
	assign out_red      = red_s4;
	assign out_green    = green_s4;
	assign out_blue     = blue_s4;

endmodule

// ===== rtl/core/abp_checker.sv =====
// Port-level checker for the alpha blend pixel top level, with its bind.
// Depends on assert_macros.svh and abp_pkg.
`include "assert_macros.svh"

module abp_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic                                done,
	input logic                                write_enable,
	input logic [abp_pkg::CHAN_W-1:0]          out_alpha,
	input logic [abp_pkg::CHAN_W-1:0]          out_red,
	input logic [abp_pkg::CHAN_W-1:0]          out_green,
	input logic [abp_pkg::CHAN_W-1:0]          out_blue
);

	// Every accepted word yields a result.
	`ABP_ASSERT(a_latency, clk, arst_n, (start && !busy) |-> ##4 done)

	// No result without an earlier accepted word.
	`ABP_ASSERT(a_no_spurious, clk, arst_n, done |-> $past(start && !busy, 4))

	// A skipped pixel carries all-zero channels.
	`ABP_ASSERT(a_skip_zero, clk, arst_n,
		(done && !write_enable) |-> (out_alpha == '0 && out_red == '0
		&& out_green == '0 && out_blue == '0))

	// A written pixel has nonzero alpha.
	`ABP_NEVER(a_written_alpha, clk, arst_n, done && write_enable && (out_alpha == '0))

endmodule

bind alpha_blend_pixel_top abp_checker u_abp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.write_enable (write_enable),
	.out_alpha    (out_alpha),
	.out_red      (out_red),
	.out_green    (out_green),
	.out_blue     (out_blue)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for alpha_blend_pixel_top: source-over pixel blending with clipping.
// Depends on abp_pkg and the RTL top; predicts each result word in-bench.
module tb_top;
	import abp_pkg::*;

	// Register index that maps to nothing; a write to it must be dropped.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned CYCLE_LIMIT  = 200000;

	// One input word: coordinates plus source and destination pixels.
	typedef struct {
		logic signed [COORD_W-1:0] dest_x;
		logic signed [COORD_W-1:0] dest_y;
		logic [CHAN_W-1:0]         src_alpha;
		logic [CHAN_W-1:0]         src_red;
		logic [CHAN_W-1:0]         src_green;
		logic [CHAN_W-1:0]         src_blue;
		logic [CHAN_W-1:0]         dst_alpha;
		logic [CHAN_W-1:0]         dst_red;
		logic [CHAN_W-1:0]         dst_green;
		logic [CHAN_W-1:0]         dst_blue;
	} pixel_t;

	// One result word.
	typedef struct {
		logic              write_enable;
		logic [CHAN_W-1:0] alpha;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} blend_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Every block input starts at a known value.
	logic                      start = 1'b0;
	logic                      busy;
	logic signed [COORD_W-1:0] dest_x = '0;
	logic signed [COORD_W-1:0] dest_y = '0;
	logic [CHAN_W-1:0]         src_alpha = '0;
	logic [CHAN_W-1:0]         src_red = '0;
	logic [CHAN_W-1:0]         src_green = '0;
	logic [CHAN_W-1:0]         src_blue = '0;
	logic [CHAN_W-1:0]         dst_alpha = '0;
	logic [CHAN_W-1:0]         dst_red = '0;
	logic [CHAN_W-1:0]         dst_green = '0;
	logic [CHAN_W-1:0]         dst_blue = '0;
	logic                      done;
	logic                      write_enable;
	logic [CHAN_W-1:0]         out_alpha;
	logic [CHAN_W-1:0]         out_red;
	logic [CHAN_W-1:0]         out_green;
	logic [CHAN_W-1:0]         out_blue;
	logic                      cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_index = CFG_GLOBAL_ALPHA;
	logic [DIM_W-1:0]          cfg_data = '0;

	alpha_blend_pixel_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.dest_x       (dest_x),
		.dest_y       (dest_y),
		.src_alpha    (src_alpha),
		.src_red      (src_red),
		.src_green    (src_green),
		.src_blue     (src_blue),
		.dst_alpha    (dst_alpha),
		.dst_red      (dst_red),
		.dst_green    (dst_green),
		.dst_blue     (dst_blue),
		.done         (done),
		.write_enable (write_enable),
		.out_alpha    (out_alpha),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Bench copy of the configuration, tracked write by write.
	logic [CHAN_W-1:0] ga_reg     = RST_GLOBAL_ALPHA;
	logic [DIM_W-1:0]  width_reg  = RST_SURFACE_WIDTH;
	logic [DIM_W-1:0]  height_reg = RST_SURFACE_HEIGHT;

	pixel_t      pixel_q[$];    // words waiting to be sent
	blend_t      blended_q[$];  // predicted results, oldest first
	pixel_t      cur_pix;       // word currently on the input ports
	bit          taken = 1'b0;  // cur_pix was accepted at the last rising edge
	bit          steady = 1'b0; // suppress sender gaps
	int unsigned n_mismatch = 0;
	int unsigned n_cycles = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Non-premultiplied channel mix, truncating divide by 255.
	function automatic logic [CHAN_W-1:0] mix_channel(input logic [CHAN_W-1:0] s,
		input logic [CHAN_W-1:0] d, input int unsigned a);
		int unsigned sum;
		sum = 32'(s) * a + 32'(d) * (255 - a);
		return CHAN_W'(sum / 255);
	endfunction

	// Work out the result word for one pixel under the current configuration.
	function automatic blend_t composite_pixel(input pixel_t p);
		blend_t      r;
		int          x;
		int          y;
		int unsigned w;
		int unsigned h;
		int unsigned a;
		r.write_enable = 1'b0;
		r.alpha = '0;
		r.red = '0;
		r.green = '0;
		r.blue = '0;
		x = p.dest_x;
		y = p.dest_y;
		// Oversized surfaces clip at the largest supported size.
		w = (width_reg > MAX_DIM) ? 32'(MAX_DIM) : 32'(width_reg);
		h = (height_reg > MAX_DIM) ? 32'(MAX_DIM) : 32'(height_reg);
		if (x < 0 || y < 0 || x >= int'(w) || y >= int'(h))
			return r;
		a = (32'(p.src_alpha) * 32'(ga_reg)) / 255;
		if (a == 0)
			return r;
		r.write_enable = 1'b1;
		if (a == 255) begin
			// Fully opaque: replace the destination outright.
			r.alpha = CHAN_MAX;
			r.red = p.src_red;
			r.green = p.src_green;
			r.blue = p.src_blue;
			return r;
		end
		r.alpha = CHAN_W'(a + (32'(p.dst_alpha) * (255 - a)) / 255);
		r.red = mix_channel(p.src_red, p.dst_red, a);
		r.green = mix_channel(p.src_green, p.dst_green, a);
		r.blue = mix_channel(p.src_blue, p.dst_blue, a);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Driver: present words at the falling edge, hold while busy.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !taken) begin
			// Word not taken yet: hold it.
		end else begin
			taken = 1'b0;
			if (pixel_q.size() > 0 && (steady || $urandom_range(99) >= 26)) begin
				cur_pix = pixel_q.pop_front();
				dest_x    <= cur_pix.dest_x;
				dest_y    <= cur_pix.dest_y;
				src_alpha <= cur_pix.src_alpha;
				src_red   <= cur_pix.src_red;
				src_green <= cur_pix.src_green;
				src_blue  <= cur_pix.src_blue;
				dst_alpha <= cur_pix.dst_alpha;
				dst_red   <= cur_pix.dst_red;
				dst_green <= cur_pix.dst_green;
				dst_blue  <= cur_pix.dst_blue;
				start     <= 1'b1;
			end else begin
				// Idle this cycle, or nothing left to send.
				start <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: check results and record accepted words at the rising edge.
	// Check before predicting, so a word taken at this edge never matches
	// a result that leaves at the same edge.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		blend_t want;
		if (arst_n) begin
			if (done) begin
				if (blended_q.size() == 0) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("[%0t] result word with nothing expected: we=%0b argb=%02h%02h%02h%02h",
							$realtime, write_enable, out_alpha, out_red, out_green, out_blue);
				end else begin
					want = blended_q.pop_front();
					if (write_enable !== want.write_enable || out_alpha !== want.alpha ||
						out_red !== want.red || out_green !== want.green ||
						out_blue !== want.blue) begin
						n_mismatch++;
						if (n_mismatch <= 10)
							$display("[%0t] mismatch: expected we=%0b argb=%02h%02h%02h%02h, got we=%0b argb=%02h%02h%02h%02h",
								$realtime, want.write_enable, want.alpha, want.red, want.green,
								want.blue, write_enable, out_alpha, out_red, out_green, out_blue);
					end
				end
			end
			if (start && !busy) begin
				blended_q.push_back(composite_pixel(cur_pix));
				taken = 1'b1;
			end
		end
	end

	// Watchdog: end a hung run.
	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic pixel_t make_pixel(input int x, input int y, input int sa,
		input int sr, input int sg, input int sb, input int da, input int dr,
		input int dg, input int db);
		pixel_t p;
		p.dest_x = COORD_W'(x);
		p.dest_y = COORD_W'(y);
		p.src_alpha = CHAN_W'(sa);
		p.src_red = CHAN_W'(sr);
		p.src_green = CHAN_W'(sg);
		p.src_blue = CHAN_W'(sb);
		p.dst_alpha = CHAN_W'(da);
		p.dst_red = CHAN_W'(dr);
		p.dst_green = CHAN_W'(dg);
		p.dst_blue = CHAN_W'(db);
		return p;
	endfunction

	// Pick an alpha that favors the opaque and transparent corners.
	function automatic int pick_alpha();
		case ($urandom_range(9))
			0: return 0;
			1: return 255;
			2: return 1;
			3: return 254;
			default: return $urandom_range(255);
		endcase
	endfunction

	// Random pixel, mostly inside the surface, some on its edges, some anywhere.
	function automatic pixel_t random_pixel();
		int unsigned w;
		int unsigned h;
		int unsigned pick;
		int          x;
		int          y;
		w = (width_reg > MAX_DIM) ? 32'(MAX_DIM) : 32'(width_reg);
		h = (height_reg > MAX_DIM) ? 32'(MAX_DIM) : 32'(height_reg);
		pick = $urandom_range(99);
		if (pick < 65 && w > 0 && h > 0) begin
			x = $urandom_range(w - 1, 0);
			y = $urandom_range(h - 1, 0);
		end else if (pick < 80) begin
			// Straddle the right or bottom border, or step just below zero.
			x = $urandom_range(2) == 0 ? -1 : int'(w) - 1 + int'($urandom_range(1));
			y = $urandom_range(2) == 0 ? -1 : int'(h) - 1 + int'($urandom_range(1));
		end else begin
			x = $urandom_range(8191);
			y = $urandom_range(8191);
		end
		return make_pixel(x, y, pick_alpha(), $urandom_range(255), $urandom_range(255),
			$urandom_range(255), pick_alpha(), $urandom_range(255), $urandom_range(255),
			$urandom_range(255));
	endfunction

	// Write one register at a rising edge and track it in the bench copy.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= DIM_W'(value);
		@(posedge clk);
		case (idx)
			CFG_GLOBAL_ALPHA:   ga_reg = CHAN_W'(value);
			CFG_SURFACE_WIDTH:  width_reg = DIM_W'(value);
			CFG_SURFACE_HEIGHT: height_reg = DIM_W'(value);
			default: ; // unmapped index: dropped
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic setup(input int unsigned ga, input int unsigned w, input int unsigned h);
		write_reg(CFG_GLOBAL_ALPHA, ga);
		write_reg(CFG_SURFACE_WIDTH, w);
		write_reg(CFG_SURFACE_HEIGHT, h);
	endtask

	// Wait until every word is sent and every result is back.
	task automatic drain();
		while (pixel_q.size() > 0 || start || blended_q.size() > 0)
			@(posedge clk);
	endtask

	task automatic push_random(input int n);
		repeat (n) pixel_q.push_back(random_pixel());
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		int k;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed words on the reset configuration (alpha 255, 640 x 480).
		pixel_q.push_back(make_pixel(0, 0, 255, 12, 34, 56, 7, 8, 9, 10));        // opaque
		pixel_q.push_back(make_pixel(639, 479, 255, 255, 255, 255, 0, 0, 0, 0));  // far corner
		pixel_q.push_back(make_pixel(640, 0, 255, 1, 2, 3, 4, 5, 6, 7));          // right edge
		pixel_q.push_back(make_pixel(0, 480, 255, 1, 2, 3, 4, 5, 6, 7));          // bottom edge
		pixel_q.push_back(make_pixel(-1, 5, 200, 1, 2, 3, 4, 5, 6, 7));           // negative x
		pixel_q.push_back(make_pixel(5, -1, 200, 1, 2, 3, 4, 5, 6, 7));           // negative y
		pixel_q.push_back(make_pixel(-4096, -4096, 255, 255, 255, 255, 255, 255, 255, 255));
		pixel_q.push_back(make_pixel(4095, 4095, 255, 255, 255, 255, 255, 255, 255, 255));
		pixel_q.push_back(make_pixel(10, 10, 0, 255, 255, 255, 9, 9, 9, 9));      // transparent
		pixel_q.push_back(make_pixel(1, 1, 1, 255, 255, 255, 0, 0, 0, 0));
		pixel_q.push_back(make_pixel(2, 2, 254, 0, 0, 0, 255, 255, 255, 255));
		pixel_q.push_back(make_pixel(3, 3, 128, 255, 255, 255, 255, 255, 255, 255));
		pixel_q.push_back(make_pixel(4, 4, 128, 0, 0, 0, 0, 0, 0, 0));
		pixel_q.push_back(make_pixel(5, 5, 77, 170, 85, 240, 128, 85, 170, 15));
		pixel_q.push_back(make_pixel(639, 0, 100, 200, 100, 50, 60, 70, 80, 90));
		pixel_q.push_back(make_pixel(0, 479, 100, 200, 100, 50, 60, 70, 80, 90));
		drain();

		// Global alpha zero: nothing is written, even fully opaque sources.
		write_reg(CFG_GLOBAL_ALPHA, 0);
		pixel_q.push_back(make_pixel(3, 3, 255, 255, 255, 255, 0, 0, 0, 0));
		push_random(30);
		drain();

		// Global alpha one on a 1 x 1 surface: only opaque sources survive.
		setup(1, 1, 1);
		pixel_q.push_back(make_pixel(0, 0, 255, 255, 128, 0, 10, 20, 30, 40));
		pixel_q.push_back(make_pixel(0, 0, 254, 255, 128, 0, 10, 20, 30, 40));
		pixel_q.push_back(make_pixel(1, 0, 255, 255, 128, 0, 10, 20, 30, 40));
		pixel_q.push_back(make_pixel(0, 1, 255, 255, 128, 0, 10, 20, 30, 40));
		push_random(40);
		drain();

		// Largest surface, back-to-back words with no sender gaps.
		setup(255, 4096, 4096);
		steady = 1'b1;
		pixel_q.push_back(make_pixel(4095, 4095, 255, 1, 2, 3, 4, 5, 6, 7));
		push_random(200);
		drain();
		steady = 1'b0;

		// Zero width clips everything.
		setup(128, 0, 100);
		push_random(30);
		drain();

		// Sizes beyond the limit clip at the largest supported size.
		setup(200, 8191, 4097);
		pixel_q.push_back(make_pixel(4095, 4095, 255, 90, 80, 70, 60, 50, 40, 30));
		push_random(150);
		drain();

		// A write to the unmapped index must leave every register alone.
		write_reg(CFG_UNUSED, 0);
		push_random(50);
		drain();

		// Random settings, extremes mixed in.
		for (k = 0; k < 4; k++) begin
			setup(pick_alpha(), $urandom_range(2) == 0 ? 4096 : $urandom_range(4096, 1),
				$urandom_range(2) == 0 ? 4096 : $urandom_range(4096, 1));
			push_random(100);
			drain();
		end

		// Let the pipeline settle so stray result words get caught.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_mismatch == 0 && blended_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
